// ===== hdl/bpra_pkg.sv =====
package bpra_pkg;

   localparam int MAP_WORDS   = 8;
   localparam int WORD_BITS   = 64;
   localparam int PAGE_BYTES  = 4096;
   localparam int TOTAL_PAGES = MAP_WORDS * WORD_BITS;
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int WORD_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int PAGE_W      = WORD_W + BIT_W;
   localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
   localparam int CNT_W       = 10;
   localparam int ADDR_W      = 64;
   localparam int STATUS_W    = 2;
   localparam int LEN_W       = (PAGE_W + 1 > CNT_W) ? PAGE_W + 1 : CNT_W;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_NO_ROOM = 2'd1,
      ST_BAD     = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_UPD_RD,
      S_UPD_WR,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic              rd_en;
      logic [WORD_W-1:0] rd_addr;
      logic              wr_en;
      logic [WORD_W-1:0] wr_addr;
      word_type          wr_data;
   } store_req_type;

   typedef struct packed {
      word_type rd_data;
      logic     empty;
      logic     full;
   } store_rsp_type;

   typedef struct packed {
      logic             hit;
      logic [BIT_W-1:0] pos;
      logic [LEN_W-1:0] run_out;
   } scan_res_type;

endpackage

// ===== hdl/bpra_req_if.sv =====
interface bpra_req_if;
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic [bpra_pkg::CNT_W-1:0]   page_count;
   logic [bpra_pkg::ADDR_W-1:0]  page_address;

   modport source (output valid, command, page_count, page_address, input ready);
   modport sink (input valid, command, page_count, page_address, output ready);
endinterface

// ===== hdl/bpra_rsp_if.sv =====
interface bpra_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bpra_pkg::STATUS_W-1:0]  status;
   logic [bpra_pkg::ADDR_W-1:0]    granted_address;
   logic                           region_empty;
   logic                           region_full;

   modport source (output valid, status, granted_address, region_empty, region_full,
                   input ready);
   modport sink (input valid, status, granted_address, region_empty, region_full,
                 output ready);
endinterface

// ===== hdl/bpra_store.sv =====
module bpra_store (
   input  logic                    clock,
   input  logic                    reset,
   input  bpra_pkg::store_req_type req_in,
   output bpra_pkg::store_rsp_type rsp_out
);

   bpra_pkg::word_type                 occ_mem_ff [bpra_pkg::MAP_WORDS];
   bpra_pkg::word_type                 rd_q_ff;
   logic                               rd_vld_ff;
   logic [bpra_pkg::MAP_WORDS-1:0]     vld_ff;
   logic [bpra_pkg::MAP_WORDS-1:0]     zero_ff;
   logic [bpra_pkg::MAP_WORDS-1:0]     ones_ff;

   always_ff @(posedge clock) begin
      if (req_in.wr_en) begin
         occ_mem_ff[req_in.wr_addr] <= req_in.wr_data;
      end
      if (req_in.rd_en) begin
         rd_q_ff <= occ_mem_ff[req_in.rd_addr];
      end
   end

   // track written entries and per-word empty/full summaries
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         zero_ff   <= '1;
         ones_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (req_in.wr_en) begin
            vld_ff[req_in.wr_addr]  <= 1'b1;
            zero_ff[req_in.wr_addr] <= (req_in.wr_data == '0);
            ones_ff[req_in.wr_addr] <= (req_in.wr_data == '1);
         end
         if (req_in.rd_en) begin
            rd_vld_ff <= vld_ff[req_in.rd_addr];
         end
      end
   end

   assign rsp_out.rd_data = rd_vld_ff ? rd_q_ff : '0;
   assign rsp_out.empty   = &zero_ff;
   assign rsp_out.full    = &ones_ff;

   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      (req_in.wr_en && req_in.rd_en) |-> (req_in.wr_addr != req_in.rd_addr))
      else $error("read and write hit the same bitmap word");

   a_empty_full_excl: assert property (@(posedge clock) disable iff (reset)
      !(rsp_out.empty && rsp_out.full))
      else $error("bitmap reported empty and full at once");

endmodule

// ===== hdl/bpra_scan.sv =====
module bpra_scan (
   input  bpra_pkg::word_type                used_word,
   input  logic [bpra_pkg::LEN_W-1:0]        prior_run,
   input  logic [bpra_pkg::CNT_W-1:0]        count,
   output bpra_pkg::scan_res_type            res
);

   localparam int BW = bpra_pkg::BIT_W;
   localparam int WB = bpra_pkg::WORD_BITS;
   localparam int LW = bpra_pkg::LEN_W;

   logic [BW:0]     r_lvl [BW+1][WB];
   logic [LW:0]     total [WB];
   logic [WB-1:0]   hit_vec;

   // free-run length ending at each bit, by doubling
   always_comb begin
      for (int j = 0; j < WB; j++) begin
         r_lvl[0][j] = {{BW{1'b0}}, ~used_word[j]};
      end
      for (int k = 0; k < BW; k++) begin
         for (int j = 0; j < WB; j++) begin
            if (r_lvl[k][j] == (BW+1)'(1 << k) && j >= (1 << k)) begin
               r_lvl[k+1][j] = r_lvl[k][j]
                             + r_lvl[k][j - ((j >= (1 << k)) ? (1 << k) : 0)];
            end else begin
               r_lvl[k+1][j] = r_lvl[k][j];
            end
         end
      end
      for (int j = 0; j < WB; j++) begin
         total[j] = (LW+1)'(r_lvl[BW][j])
                  + ((r_lvl[BW][j] == (BW+1)'(j + 1)) ? {1'b0, prior_run} : '0);
         hit_vec[j] = (total[j] >= (LW+1)'(count));
      end
      res.hit = |hit_vec;
      res.pos = '0;
      for (int j = WB - 1; j >= 0; j--) begin
         if (hit_vec[j]) begin
            res.pos = BW'(j);
         end
      end
      res.run_out = total[WB-1][LW-1:0];
   end

endmodule

// ===== hdl/bitmap_page_run_allocator.sv =====
// Channel  | Direction | Payload
// req_chan | in        | command, page_count, page_address
// rsp_chan | out       | status, granted_address, region_empty, region_full
// csr      | in        | region_base (write only)
//
// One request at a time. Errors go from the check state straight to the result. The
// bitmap memory has one read port and one write port and can read one word and write
// one word per cycle, so allocate scans and then marks the bitmap word by word, and
// free clears it word by word. Reset clears the bitmap at once through per-word valid
// flags. A stalled result holds in the output register; the next request is taken while it waits.
module bitmap_page_run_allocator (
   input  logic                          clock,
   input  logic                          reset,
   bpra_req_if.sink                      req_chan,
   bpra_rsp_if.source                    rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [bpra_pkg::ADDR_W-1:0]   csr_wr_data
);

   localparam int WW = bpra_pkg::WORD_W;
   localparam int PW = bpra_pkg::PAGE_W;
   localparam int BW = bpra_pkg::BIT_W;
   localparam int LW = bpra_pkg::LEN_W;
   localparam int AW = bpra_pkg::ADDR_W;

   bpra_pkg::state_type          state_ff, state_in;
   bpra_pkg::status_type         status_ff, status_in;
   logic                         cmd_ff, cmd_in;
   logic [bpra_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [AW-1:0]                diff_ff, diff_in;
   logic                         below_ff, below_in;
   logic [AW-1:0]                base_ff;
   logic [LW-1:0]                run_ff, run_in;
   logic [WW-1:0]                word_ff, word_in;
   logic [PW-1:0]                first_pg_ff, first_pg_in;
   logic [PW-1:0]                last_pg_ff, last_pg_in;
   logic                         set_ff, set_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   bpra_pkg::status_type         rsp_status_ff;
   logic [AW-1:0]                rsp_granted_ff;
   logic                         rsp_empty_ff;
   logic                         rsp_full_ff;
   logic                         rsp_load;

   bpra_pkg::store_req_type      st_req;
   bpra_pkg::store_rsp_type      st_rsp;
   bpra_pkg::scan_res_type       scan_res;

   logic [PW-1:0]                free_first;
   logic [LW:0]                  free_reach;
   logic [PW-1:0]                hit_last;
   logic [BW-1:0]                lo_bit, hi_bit;
   bpra_pkg::word_type           run_mask;

   bpra_store u_store (
      .clock   (clock),
      .reset   (reset),
      .req_in  (st_req),
      .rsp_out (st_rsp)
   );

   bpra_scan u_scan (
      .used_word (st_rsp.rd_data),
      .prior_run (run_ff),
      .count     (count_ff),
      .res       (scan_res)
   );

   assign free_first = diff_ff[bpra_pkg::PAGE_SHIFT +: PW];
   assign free_reach = (LW+1)'(free_first) + (LW+1)'(count_ff);
   assign hit_last   = {word_ff, scan_res.pos};
   assign lo_bit     = (word_ff == first_pg_ff[PW-1:BW]) ? first_pg_ff[BW-1:0] : '0;
   assign hi_bit     = (word_ff == last_pg_ff[PW-1:BW]) ? last_pg_ff[BW-1:0] : '1;
   assign run_mask   = ({bpra_pkg::WORD_BITS{1'b1}} << lo_bit)
                     & ({bpra_pkg::WORD_BITS{1'b1}} >> (BW'(bpra_pkg::WORD_BITS - 1) - hi_bit));

   assign req_chan.ready = (state_ff == bpra_pkg::S_IDLE);

   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      diff_in      = diff_ff;
      below_in     = below_ff;
      run_in       = run_ff;
      word_in      = word_ff;
      first_pg_in  = first_pg_ff;
      last_pg_in   = last_pg_ff;
      set_in       = set_ff;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      st_req       = '0;

      unique case (state_ff)
         bpra_pkg::S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in   = req_chan.command;
               count_in = req_chan.page_count;
               diff_in  = req_chan.page_address - base_ff;
               below_in = (req_chan.page_address < base_ff);
               state_in = bpra_pkg::S_CHECK;
            end
         end
         bpra_pkg::S_CHECK: begin
            status_in = bpra_pkg::ST_DONE;
            if (count_ff == '0) begin
               status_in = bpra_pkg::ST_BAD;
               state_in  = bpra_pkg::S_FINISH;
            end else if (cmd_ff == bpra_pkg::CMD_ALLOC) begin
               if ((LW+1)'(count_ff) > (LW+1)'(bpra_pkg::TOTAL_PAGES)) begin
                  status_in = bpra_pkg::ST_NO_ROOM;
                  state_in  = bpra_pkg::S_FINISH;
               end else begin
                  st_req.rd_en   = 1'b1;
                  st_req.rd_addr = '0;
                  word_in        = '0;
                  run_in         = '0;
                  state_in       = bpra_pkg::S_SCAN;
               end
            end else begin
               if (below_ff || ((diff_ff >> (bpra_pkg::PAGE_SHIFT + PW)) != '0)
                   || free_reach > (LW+1)'(bpra_pkg::TOTAL_PAGES)) begin
                  status_in = bpra_pkg::ST_BAD;
                  state_in  = bpra_pkg::S_FINISH;
               end else begin
                  first_pg_in = free_first;
                  last_pg_in  = PW'(free_reach - (LW+1)'(1));
                  set_in      = 1'b0;
                  state_in    = bpra_pkg::S_UPD_RD;
               end
            end
         end
         bpra_pkg::S_SCAN: begin
            if (scan_res.hit) begin
               last_pg_in  = hit_last;
               first_pg_in = PW'((LW+1)'(hit_last) + (LW+1)'(1) - (LW+1)'(count_ff));
               set_in      = 1'b1;
               state_in    = bpra_pkg::S_UPD_RD;
            end else if (word_ff == WW'(bpra_pkg::MAP_WORDS - 1)) begin
               status_in = bpra_pkg::ST_NO_ROOM;
               state_in  = bpra_pkg::S_FINISH;
            end else begin
               run_in         = scan_res.run_out;
               word_in        = WW'(word_ff + 1'b1);
               st_req.rd_en   = 1'b1;
               st_req.rd_addr = WW'(word_ff + 1'b1);
            end
         end
         bpra_pkg::S_UPD_RD: begin
            st_req.rd_en   = 1'b1;
            st_req.rd_addr = first_pg_ff[PW-1:BW];
            word_in        = first_pg_ff[PW-1:BW];
            state_in       = bpra_pkg::S_UPD_WR;
         end
         bpra_pkg::S_UPD_WR: begin
            st_req.wr_en   = 1'b1;
            st_req.wr_addr = word_ff;
            st_req.wr_data = set_ff ? (st_rsp.rd_data | run_mask)
                                    : (st_rsp.rd_data & ~run_mask);
            if (word_ff == last_pg_ff[PW-1:BW]) begin
               state_in = bpra_pkg::S_FINISH;
            end else begin
               st_req.rd_en   = 1'b1;
               st_req.rd_addr = WW'(word_ff + 1'b1);
               word_in        = WW'(word_ff + 1'b1);
            end
         end
         bpra_pkg::S_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = bpra_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bpra_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpra_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            base_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      cmd_ff      <= cmd_in;
      count_ff    <= count_in;
      diff_ff     <= diff_in;
      below_ff    <= below_in;
      run_ff      <= run_in;
      word_ff     <= word_in;
      first_pg_ff <= first_pg_in;
      last_pg_ff  <= last_pg_in;
      set_ff      <= set_in;
      if (rsp_load) begin
         rsp_status_ff  <= status_ff;
         rsp_granted_ff <= (status_ff == bpra_pkg::ST_DONE && cmd_ff == bpra_pkg::CMD_ALLOC)
                         ? base_ff + (AW'(first_pg_ff) << bpra_pkg::PAGE_SHIFT) : '0;
         rsp_empty_ff   <= st_rsp.empty;
         rsp_full_ff    <= st_rsp.full;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.granted_address = rsp_granted_ff;
   assign rsp_chan.region_empty    = rsp_empty_ff;
   assign rsp_chan.region_full     = rsp_full_ff;

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == bpra_pkg::S_CHECK))
      else $error("accepted request did not enter check");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpra_pkg::S_FINISH && rsp_valid_ff && !rsp_chan.ready)
      |=> (state_ff == bpra_pkg::S_FINISH) && $stable(rsp_granted_ff))
      else $error("result overwritten while output stalled");

   a_hit_in_map: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpra_pkg::S_SCAN && scan_res.hit)
      |-> ((LW+1)'(count_ff) <= (LW+1)'(hit_last) + (LW+1)'(1)))
      else $error("found run starts before page zero");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam int AW = bpra_pkg::ADDR_W;
   localparam int CW = bpra_pkg::CNT_W;
   localparam int TP = bpra_pkg::TOTAL_PAGES;

   typedef struct packed {
      logic          command;
      logic [CW-1:0] page_count;
      logic [AW-1:0] page_address;
   } page_request_type;

   typedef struct packed {
      bpra_pkg::status_type status;
      logic [AW-1:0]        granted_address;
      logic                 region_empty;
      logic                 region_full;
   } page_reply_type;

   localparam logic [AW-1:0] DIRECT_BASE = 64'h0000_0010_0000_0000;
   localparam logic [AW-1:0] WRAP_BASE   = 64'hFFFF_FFFF_FFF0_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic             req_valid   = 1'b0;
   page_request_type req_drive   = '0;
   logic             rsp_ready   = 1'b0;
   logic             csr_wr_en   = 1'b0;
   logic [AW-1:0]    csr_wr_data = '0;

   page_request_type request_backlog[$];
   page_reply_type   predicted_replies[$];

   logic [TP-1:0] page_map    = '0;
   logic [AW-1:0] region_base = '0;
   int send_idle_pct  = 0;
   int hold_pct       = 0;
   int mismatch_count = 0;

   bpra_req_if req_if ();
   bpra_rsp_if rsp_if ();

   assign req_if.valid        = req_valid;
   assign req_if.command      = req_drive.command;
   assign req_if.page_count   = req_drive.page_count;
   assign req_if.page_address = req_drive.page_address;
   assign rsp_if.ready        = rsp_ready;

   bitmap_page_run_allocator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic page_reply_type apply_page_request(page_request_type rq);
      page_reply_type rp;
      int             run;
      int             start;
      int             p;
      bit             found;
      logic [AW-1:0]  offset;
      logic [AW-1:0]  first;
      rp.status          = bpra_pkg::ST_DONE;
      rp.granted_address = '0;
      run   = 0;
      start = 0;
      found = 1'b0;
      if (rq.page_count == 0) begin
         rp.status = bpra_pkg::ST_BAD;
      end else if (rq.command == bpra_pkg::CMD_ALLOC) begin
         if (rq.page_count <= TP) begin
            for (p = 0; p < TP && !found; p++) begin
               if (page_map[p]) begin
                  run = 0;
               end else begin
                  if (run == 0) start = p;
                  run++;
                  if (run == rq.page_count) found = 1'b1;
               end
            end
         end
         if (found) begin
            for (p = start; p < start + rq.page_count; p++) page_map[p] = 1'b1;
            offset = AW'(start);
            rp.granted_address = region_base + (offset << bpra_pkg::PAGE_SHIFT);
         end else begin
            rp.status = bpra_pkg::ST_NO_ROOM;
         end
      end else begin
         if (rq.page_address < region_base) begin
            rp.status = bpra_pkg::ST_BAD;
         end else begin
            offset = rq.page_address - region_base;
            first  = offset >> bpra_pkg::PAGE_SHIFT;
            if (first >= TP || rq.page_count > TP - first) begin
               rp.status = bpra_pkg::ST_BAD;
            end else begin
               for (p = int'(first); p < first + rq.page_count; p++) page_map[p] = 1'b0;
            end
         end
      end
      rp.region_empty = (page_map == '0);
      rp.region_full  = &page_map;
      return rp;
   endfunction

   function automatic logic [AW-1:0] page_addr(int page);
      logic [AW-1:0] a;
      a = AW'(page);
      return region_base + (a << bpra_pkg::PAGE_SHIFT);
   endfunction

   function automatic page_request_type random_request();
      page_request_type rq;
      int roll;
      int first;
      int lim;
      roll = int'($urandom_range(99, 0));
      rq.page_address = {$urandom, $urandom};
      if (roll < 40) begin
         rq.command = bpra_pkg::CMD_ALLOC;
         roll = int'($urandom_range(99, 0));
         if (roll < 88)      rq.page_count = CW'($urandom_range(16, 1));
         else if (roll < 98) rq.page_count = CW'($urandom_range(128, 1));
         else                rq.page_count = CW'($urandom_range(TP, 129));
      end else if (roll < 80) begin
         rq.command = bpra_pkg::CMD_FREE;
         if ($urandom_range(99, 0) < 3) begin
            rq.page_count   = CW'(TP);
            rq.page_address = region_base;
         end else begin
            first = int'($urandom_range(TP - 1, 0));
            lim   = TP - first;
            if (lim > 64) lim = 64;
            rq.page_count   = CW'($urandom_range(lim, 1));
            rq.page_address = page_addr(first)
                            + AW'($urandom_range(bpra_pkg::PAGE_BYTES - 1, 0));
         end
      end else begin
         rq.command    = 1'($urandom_range(1, 0));
         rq.page_count = CW'($urandom_range(1023, 0));
         if ($urandom_range(3, 0) == 0)
            rq.page_address = region_base - AW'($urandom_range(bpra_pkg::PAGE_BYTES, 1));
      end
      return rq;
   endfunction

   task automatic queue_request(logic cmd, int count, logic [AW-1:0] addr);
      page_request_type rq;
      rq.command      = cmd;
      rq.page_count   = CW'(count);
      rq.page_address = addr;
      request_backlog.push_back(rq);
   endtask

   task automatic set_region_base(logic [AW-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      region_base = value;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (request_backlog.size() != 0 || req_valid || predicted_replies.size() != 0);
   endtask

   task automatic report_field(string field, logic [AW-1:0] want, logic [AW-1:0] got);
      if (got !== want) begin
         $display("%0t %s expected %h actual %h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_if.ready)
            predicted_replies.push_back(apply_page_request(req_drive));
         if (!req_valid || req_if.ready) begin
            if (request_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               req_drive <= request_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   page_reply_type want_reply;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_ready) begin
            if (predicted_replies.size() == 0) begin
               $display("%0t reply with none expected: status %h granted %h", $time,
                        rsp_if.status, rsp_if.granted_address);
               mismatch_count++;
            end else begin
               want_reply = predicted_replies.pop_front();
               report_field("status", AW'(want_reply.status), AW'(rsp_if.status));
               report_field("granted_address", want_reply.granted_address,
                            rsp_if.granted_address);
               report_field("region_empty", AW'(want_reply.region_empty),
                            AW'(rsp_if.region_empty));
               report_field("region_full", AW'(want_reply.region_full),
                            AW'(rsp_if.region_full));
            end
         end
         rsp_ready <= ($urandom_range(99, 0) >= hold_pct);
      end
   end

   initial begin : stimulus
      logic [AW-1:0] bases [8];
      int ph;
      int n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      set_region_base(DIRECT_BASE);
      queue_request(bpra_pkg::CMD_ALLOC, 0, '0);
      queue_request(bpra_pkg::CMD_FREE, 0, DIRECT_BASE);
      queue_request(bpra_pkg::CMD_ALLOC, 1, '0);
      queue_request(bpra_pkg::CMD_ALLOC, 1023, '1);
      queue_request(bpra_pkg::CMD_ALLOC, TP, '0);
      queue_request(bpra_pkg::CMD_FREE, 1, DIRECT_BASE + 64'h123);
      queue_request(bpra_pkg::CMD_ALLOC, TP, '0);
      queue_request(bpra_pkg::CMD_ALLOC, 1, '0);
      queue_request(bpra_pkg::CMD_FREE, 1, DIRECT_BASE - 64'd1);
      queue_request(bpra_pkg::CMD_FREE, 2, page_addr(TP - 1));
      queue_request(bpra_pkg::CMD_FREE, 1023, DIRECT_BASE);
      queue_request(bpra_pkg::CMD_FREE, 1, '1);
      queue_request(bpra_pkg::CMD_FREE, 64, page_addr(64));
      queue_request(bpra_pkg::CMD_FREE, 64, page_addr(64));
      queue_request(bpra_pkg::CMD_ALLOC, 65, '0);
      queue_request(bpra_pkg::CMD_ALLOC, 64, '0);
      queue_request(bpra_pkg::CMD_FREE, TP - 1, page_addr(1));
      queue_request(bpra_pkg::CMD_FREE, 1,
                    page_addr(TP - 1) + AW'(bpra_pkg::PAGE_BYTES - 1));
      queue_request(bpra_pkg::CMD_ALLOC, 3, '0);
      queue_request(bpra_pkg::CMD_FREE, TP, DIRECT_BASE);
      queue_request(bpra_pkg::CMD_ALLOC, 10, '0);
      queue_request(bpra_pkg::CMD_FREE, 3, page_addr(2));
      queue_request(bpra_pkg::CMD_ALLOC, 2, '0);
      wait_drained();

      set_region_base(WRAP_BASE);
      queue_request(bpra_pkg::CMD_FREE, TP, WRAP_BASE);
      queue_request(bpra_pkg::CMD_ALLOC, 300, '0);
      queue_request(bpra_pkg::CMD_ALLOC, 1, '0);
      queue_request(bpra_pkg::CMD_FREE, 1, page_addr(300));
      queue_request(bpra_pkg::CMD_FREE, TP, WRAP_BASE);
      wait_drained();

      bases[0] = '0;
      bases[1] = '1;
      bases[2] = {$urandom, $urandom};
      bases[3] = 64'h8000_0000_0000_0000;
      bases[4] = {$urandom, $urandom};
      bases[5] = WRAP_BASE;
      bases[6] = 64'h0000_0000_0000_0123;
      bases[7] = '0;
      for (ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  hold_pct = 0;  end
            1: begin send_idle_pct = 83; hold_pct = 0;  end
            2: begin send_idle_pct = 0;  hold_pct = 83; end
            default: begin send_idle_pct = 16; hold_pct = 16; end
         endcase
         set_region_base(bases[ph]);
         for (n = 0; n < 200; n++) request_backlog.push_back(random_request());
         wait_drained();
      end

      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/bpra_pkg.sv
hdl/bpra_req_if.sv
hdl/bpra_rsp_if.sv
hdl/bpra_store.sv
hdl/bpra_scan.sv
hdl/bitmap_page_run_allocator.sv
tb/testbench.sv
